@@ design/mlfd_pkg.sv @@
// shared types and constants of the marker/length frame deframer
package mlfd_pkg;

  localparam logic [15:0] START_MARK    = 16'd16018;
  localparam logic [15:0] END_MARK      = 16'd16108;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd8;
  localparam logic [15:0] MAX_LEN_RESET = 16'd8192;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_LEN   = 3'd1,
    PH_ID    = 3'd2,
    PH_BODY  = 3'd3,
    PH_END   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    K_DATA      = 3'd0,
    K_GOOD      = 3'd1,
    K_BAD_START = 3'd2,
    K_BAD_END   = 3'd3,
    K_BAD_LEN   = 3'd4
  } kind_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] packet_id;
    logic [15:0] frame_len;
  } result_t;

endpackage

@@ design/mlfd_parser.sv @@
// frame parser: phase machine, counters and per-byte result decode
module mlfd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic [15:0]       max_frame_len,
  output mlfd_pkg::result_t res
);

  mlfd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [7:0]  word_shift_r, word_shift_nxt;
  logic [15:0] total_length_r, total_length_nxt;
  logic [15:0] frame_id_r, frame_id_nxt;

  logic [15:0] cnt;
  logic [15:0] w;
  logic [15:0] end_pos;
  logic        low_half;

  assign cnt      = byte_count_r + 16'd1;
  assign w        = {in_byte, word_shift_r};
  assign end_pos  = total_length_r - 16'd2;
  assign low_half = ~byte_count_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= mlfd_pkg::PH_START;
      byte_count_r   <= '0;
      word_shift_r   <= '0;
      total_length_r <= '0;
      frame_id_r     <= '0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      word_shift_r   <= word_shift_nxt;
      total_length_r <= total_length_nxt;
      frame_id_r     <= frame_id_nxt;
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    byte_count_nxt   = cnt;
    word_shift_nxt   = word_shift_r;
    total_length_nxt = total_length_r;
    frame_id_nxt     = frame_id_r;
    res              = '0;
    res.kind         = mlfd_pkg::K_DATA;
    unique case (phase_r)
      mlfd_pkg::PH_START: begin
        if (low_half) begin
          word_shift_nxt = in_byte;
        end else if (w != mlfd_pkg::START_MARK) begin
          phase_nxt        = mlfd_pkg::PH_START;
          byte_count_nxt   = '0;
          word_shift_nxt   = '0;
          total_length_nxt = '0;
          frame_id_nxt     = '0;
          res.valid        = step;
          res.kind         = mlfd_pkg::K_BAD_START;
          res.frame_len    = cnt;
        end else begin
          phase_nxt = mlfd_pkg::PH_LEN;
        end
      end
      mlfd_pkg::PH_LEN: begin
        if (low_half) begin
          word_shift_nxt = in_byte;
        end else if (w < mlfd_pkg::MIN_FRAME_LEN || w > max_frame_len) begin
          phase_nxt        = mlfd_pkg::PH_START;
          byte_count_nxt   = '0;
          word_shift_nxt   = '0;
          total_length_nxt = '0;
          frame_id_nxt     = '0;
          res.valid        = step;
          res.kind         = mlfd_pkg::K_BAD_LEN;
          res.frame_len    = cnt;
        end else begin
          total_length_nxt = w;
          phase_nxt        = mlfd_pkg::PH_ID;
        end
      end
      mlfd_pkg::PH_ID: begin
        if (low_half) begin
          word_shift_nxt = in_byte;
        end else begin
          frame_id_nxt = w;
          phase_nxt    = (total_length_r == mlfd_pkg::MIN_FRAME_LEN) ?
                         mlfd_pkg::PH_END : mlfd_pkg::PH_BODY;
        end
      end
      mlfd_pkg::PH_BODY: begin
        if (cnt == end_pos) begin
          phase_nxt = mlfd_pkg::PH_END;
        end
        res.valid     = step;
        res.kind      = mlfd_pkg::K_DATA;
        res.data_byte = in_byte;
        res.packet_id = frame_id_r;
        res.frame_len = cnt;
      end
      mlfd_pkg::PH_END: begin
        if (byte_count_r == end_pos) begin
          word_shift_nxt = in_byte;
        end else begin
          phase_nxt        = mlfd_pkg::PH_START;
          byte_count_nxt   = '0;
          word_shift_nxt   = '0;
          total_length_nxt = '0;
          frame_id_nxt     = '0;
          res.valid        = step;
          res.kind         = (w == mlfd_pkg::END_MARK) ?
                             mlfd_pkg::K_GOOD : mlfd_pkg::K_BAD_END;
          res.packet_id    = frame_id_r;
          res.frame_len    = total_length_r;
        end
      end
      default: begin
        phase_nxt        = mlfd_pkg::PH_START;
        byte_count_nxt   = '0;
        word_shift_nxt   = '0;
        total_length_nxt = '0;
        frame_id_nxt     = '0;
      end
    endcase
  end

endmodule

@@ design/marker_length_frame_deframer_top.sv @@
// top level of the marker/length frame deframer
//
// Input channel: one received byte per transaction on in_byte, taken when
// in_valid is high and in_stall is low. Result channel: out_kind,
// out_data_byte, out_packet_id and out_frame_len, taken when out_valid is
// high and out_stall is low. A payload byte gives one result; a frame end,
// a bad start marker or a bad length gives one report; header bytes give none.
// A result is registered and appears in the cycle after its input transaction.
// One byte is taken every cycle while in_stall is low; the single output
// register lets a new byte in whenever it is empty or being taken in the same
// cycle, so in_stall is raised only while a result is held under out_stall.
// The cfg channel writes max_frame_len; cfg_ready is always high. Writes must
// be made while no frame traffic is in flight; the block does not enforce this.
// Synchronous reset (rst_n low) empties the output register, returns the
// parser to the start marker search and sets max_frame_len to 8192.
module marker_length_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_packet_id,
  output logic [15:0] out_frame_len,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0]       max_frame_len_r;
  logic              out_valid_r;
  logic              out_load;
  logic              step;
  mlfd_pkg::result_t res;
  mlfd_pkg::result_t out_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign step      = in_valid & ~in_stall;
  assign out_load  = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_len_r <= mlfd_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_frame_len_r <= cfg_data;
    end
  end

  mlfd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .in_byte       (in_byte),
    .max_frame_len (max_frame_len_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_r.kind;
  assign out_data_byte = out_r.data_byte;
  assign out_packet_id = out_r.packet_id;
  assign out_frame_len = out_r.frame_len;

`ifndef SYNTHESIS
  a_data_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != mlfd_pkg::K_DATA |-> out_data_byte == 8'd0)
    else $error("data byte set on a report");

  a_bad_start_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == mlfd_pkg::K_BAD_START |->
      out_frame_len == 16'd2 && out_packet_id == 16'd0)
    else $error("bad start report with wrong length or id");

  a_bad_len_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == mlfd_pkg::K_BAD_LEN |->
      out_frame_len == 16'd4 && out_packet_id == 16'd0)
    else $error("bad length report with wrong length or id");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");
`endif

endmodule
